[rtl/core/rsq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsq_pkg: shared types and constants
// Field widths, pipeline depths, register indexes and the beat that leaves
// the front end for the corner units.
// ----------------------------------------------------------------------------
package rsq_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_BOX_X = 2'd0;
   localparam logic [1:0] CSR_BOX_Y = 2'd1;
   localparam logic [1:0] CSR_SIDE  = 2'd2;
   localparam logic [1:0] CSR_DISC  = 2'd3;

   // register reset values
   localparam logic [15:0] BOX_RESET  = 16'hFFFF;
   localparam logic [14:0] SIDE_RESET = 15'd256;

   // stages in the front end (difference/wrap/squares, then cos/sin/distance)
   localparam int FRONT_LAT  = 2;
   // stages in one corner unit
   localparam int CORNER_LAT = 7;
   // stages ahead of the output register
   localparam int PIPE_DEPTH = FRONT_LAT + CORNER_LAT;

   // front end result: raw displacement, rotation terms, distance gates
   typedef struct packed {
      logic signed [16:0] dx;
      logic signed [16:0] dy;
      logic signed [32:0] c1;
      logic signed [32:0] s1;
      logic signed [32:0] c2;
      logic signed [32:0] s2;
      logic               far;
      logic               near;
      logic               disc;
   } rsq_front_type;

endpackage

[rtl/core/rsq_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsq_front: displacement, rotation and distance gates
// Two stages: minimum-image wrap and quaternion squares, then cos/sin and
// the squared distance compared with side^2 and 2*side^2.
// ----------------------------------------------------------------------------
module rsq_front import rsq_pkg::*; (
   input  logic          clock,
   input  logic          adv,
   input  logic [15:0]   x_first,
   input  logic [15:0]   y_first,
   input  logic [15:0]   qz_first,
   input  logic [15:0]   qw_first,
   input  logic [15:0]   x_second,
   input  logic [15:0]   y_second,
   input  logic [15:0]   qz_second,
   input  logic [15:0]   qw_second,
   input  logic [15:0]   box_x,
   input  logic [15:0]   box_y,
   input  logic [14:0]   side,
   input  logic          disc,
   output rsq_front_type front
);

   // stage 1
   logic signed [16:0] dxr_in, dyr_in, dxr_ff, dyr_ff;
   logic signed [17:0] dxw_in, dyw_in, dxw_ff, dyw_ff;
   logic signed [31:0] ww1_in, zz1_in, zw1_in, ww2_in, zz2_in, zw2_in;
   logic signed [31:0] ww1_ff, zz1_ff, zw1_ff, ww2_ff, zz2_ff, zw2_ff;
   logic [16:0]        ax, ay;
   // stage 2
   logic signed [35:0] sqx, sqy;
   logic [34:0]        d2;
   logic [29:0]        s2;
   rsq_front_type      front_in, front_ff;

   assign dxr_in = $signed({1'b0, x_second}) - $signed({1'b0, x_first});
   assign dyr_in = $signed({1'b0, y_second}) - $signed({1'b0, y_first});
   assign ax = dxr_in[16] ? 17'(-dxr_in) : dxr_in;
   assign ay = dyr_in[16] ? 17'(-dyr_in) : dyr_in;

   // wrap once when twice the distance exceeds the box length
   always_comb begin
      dxw_in = 18'(dxr_in);
      dyw_in = 18'(dyr_in);
      if ({ax, 1'b0} > {2'b00, box_x}) begin
         dxw_in = dxr_in[16] ? 18'(dxr_in) + $signed({2'b00, box_x})
                             : 18'(dxr_in) - $signed({2'b00, box_x});
      end
      if ({ay, 1'b0} > {2'b00, box_y}) begin
         dyw_in = dyr_in[16] ? 18'(dyr_in) + $signed({2'b00, box_y})
                             : 18'(dyr_in) - $signed({2'b00, box_y});
      end
   end

   assign ww1_in = $signed(qw_first) * $signed(qw_first);
   assign zz1_in = $signed(qz_first) * $signed(qz_first);
   assign zw1_in = $signed(qz_first) * $signed(qw_first);
   assign ww2_in = $signed(qw_second) * $signed(qw_second);
   assign zz2_in = $signed(qz_second) * $signed(qz_second);
   assign zw2_in = $signed(qz_second) * $signed(qw_second);

   always_ff @(posedge clock) begin
      if (adv) begin
         dxr_ff <= dxr_in;
         dyr_ff <= dyr_in;
         dxw_ff <= dxw_in;
         dyw_ff <= dyw_in;
         ww1_ff <= ww1_in;
         zz1_ff <= zz1_in;
         zw1_ff <= zw1_in;
         ww2_ff <= ww2_in;
         zz2_ff <= zz2_in;
         zw2_ff <= zw2_in;
      end
   end

   assign sqx = dxw_ff * dxw_ff;
   assign sqy = dyw_ff * dyw_ff;
   assign d2  = 35'(sqx) + 35'(sqy);
   assign s2  = side * side;

   always_comb begin
      front_in.dx   = dxr_ff;
      front_in.dy   = dyr_ff;
      front_in.c1   = 33'(ww1_ff) - 33'(zz1_ff);
      front_in.s1   = {zw1_ff, 1'b0};
      front_in.c2   = 33'(ww2_ff) - 33'(zz2_ff);
      front_in.s2   = {zw2_ff, 1'b0};
      front_in.far  = d2 > {4'b0, s2, 1'b0};
      front_in.near = d2 < {5'b0, s2};
      front_in.disc = disc;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         front_ff <= front_in;
      end
   end

   assign front = front_ff;

endmodule

[rtl/core/rsq_corner.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsq_corner: corners of one square inside the other
// Seven stages: offsets and partial products, corner wrap, exact rotated
// coordinates and strict half-side test of the four corners.
// ----------------------------------------------------------------------------
module rsq_corner import rsq_pkg::*; (
   input  logic               clock,
   input  logic               adv,
   input  logic signed [16:0] dx,
   input  logic signed [16:0] dy,
   input  logic signed [32:0] co,
   input  logic signed [32:0] so,
   input  logic signed [32:0] cf,
   input  logic signed [32:0] sf,
   input  logic [14:0]        side,
   input  logic [15:0]        lx,
   input  logic [15:0]        ly,
   output logic               hit
);

   // stage 1
   logic signed [33:0] a_in, b_in, a_ff, b_ff;
   logic signed [49:0] cdx_in, cdy_in, sdx_in, sdy_in, clx_in, cly_in, slx_in, sly_in;
   logic signed [49:0] cdx1_ff, cdy1_ff, sdx1_ff, sdy1_ff;
   logic signed [49:0] clx1_ff, cly1_ff, slx1_ff, sly1_ff;
   logic signed [32:0] cf1_ff, sf1_ff;
   logic signed [16:0] dx1_ff, dy1_ff;
   // stage 2
   logic signed [49:0] sa_in, sb_in, sa_ff, sb_ff;
   logic signed [66:0] pa_in, pb_in, qa_in, qb_in, pa_ff, pb_ff, qa_ff, qb_ff;
   logic signed [49:0] cdx2_ff, cdy2_ff, sdx2_ff, sdy2_ff;
   logic signed [49:0] clx2_ff, cly2_ff, slx2_ff, sly2_ff;
   logic signed [16:0] dx2_ff, dy2_ff;
   // stage 3
   logic signed [67:0] u_in, w_in, u_ff, w_ff;
   logic signed [50:0] vx [4];
   logic signed [50:0] vy [4];
   logic [3:0]         xs_in, xa_in, ys_in, ya_in, xs_ff, xa_ff, ys_ff, ya_ff;
   logic signed [49:0] cdx3_ff, cdy3_ff, sdx3_ff, sdy3_ff;
   logic signed [49:0] clx3_ff, cly3_ff, slx3_ff, sly3_ff;
   // stage 4
   logic signed [52:0] p1_in [4];
   logic signed [52:0] p2_in [4];
   logic signed [52:0] p1_ff [4];
   logic signed [52:0] p2_ff [4];
   logic [48:0]        rul_in, rwl_in, rul_ff, rwl_ff;
   logic signed [49:0] ruh_in, rwh_in, ruh_ff, rwh_ff;
   // stage 5
   logic signed [87:0] ru_in, rw_in, ru_ff, rw_ff;
   logic signed [52:0] p1b_ff [4];
   logic signed [52:0] p2b_ff [4];
   // stage 6
   logic signed [87:0] v1_in [4];
   logic signed [87:0] v2_in [4];
   logic signed [87:0] v1_ff [4];
   logic signed [87:0] v2_ff [4];
   // stage 7
   logic signed [87:0] lim;
   logic               hit_in, hit_ff;

   // stage 1: corner offset sums and center/box products
   assign a_in   = 34'(co) - 34'(so);
   assign b_in   = 34'(co) + 34'(so);
   assign cdx_in = cf * dx;
   assign cdy_in = cf * dy;
   assign sdx_in = sf * dx;
   assign sdy_in = sf * dy;
   assign clx_in = cf * $signed({1'b0, lx});
   assign cly_in = cf * $signed({1'b0, ly});
   assign slx_in = sf * $signed({1'b0, lx});
   assign sly_in = sf * $signed({1'b0, ly});

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff    <= a_in;
         b_ff    <= b_in;
         cdx1_ff <= cdx_in;
         cdy1_ff <= cdy_in;
         sdx1_ff <= sdx_in;
         sdy1_ff <= sdy_in;
         clx1_ff <= clx_in;
         cly1_ff <= cly_in;
         slx1_ff <= slx_in;
         sly1_ff <= sly_in;
         cf1_ff  <= cf;
         sf1_ff  <= sf;
         dx1_ff  <= dx;
         dy1_ff  <= dy;
      end
   end

   // stage 2: scaled offsets and rotation of the offsets
   assign sa_in = $signed({1'b0, side}) * a_ff;
   assign sb_in = $signed({1'b0, side}) * b_ff;
   assign pa_in = cf1_ff * a_ff;
   assign pb_in = cf1_ff * b_ff;
   assign qa_in = sf1_ff * a_ff;
   assign qb_in = sf1_ff * b_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         sa_ff   <= sa_in;
         sb_ff   <= sb_in;
         pa_ff   <= pa_in;
         pb_ff   <= pb_in;
         qa_ff   <= qa_in;
         qb_ff   <= qb_in;
         cdx2_ff <= cdx1_ff;
         cdy2_ff <= cdy1_ff;
         sdx2_ff <= sdx1_ff;
         sdy2_ff <= sdy1_ff;
         clx2_ff <= clx1_ff;
         cly2_ff <= cly1_ff;
         slx2_ff <= slx1_ff;
         sly2_ff <= sly1_ff;
         dx2_ff  <= dx1_ff;
         dy2_ff  <= dy1_ff;
      end
   end

   // stage 3: corner positions and their wrap direction
   assign u_in = 68'(pa_ff) + 68'(qb_ff);
   assign w_in = 68'(pb_ff) - 68'(qa_ff);

   always_comb begin
      logic signed [47:0] ddx, ddy;
      logic [50:0]        mag;
      ddx   = $signed({dx2_ff, 31'b0});
      ddy   = $signed({dy2_ff, 31'b0});
      vx[0] = 51'(ddx) + 51'(sa_ff);
      vx[1] = 51'(ddx) - 51'(sb_ff);
      vx[2] = 51'(ddx) + 51'(sb_ff);
      vx[3] = 51'(ddx) - 51'(sa_ff);
      vy[0] = 51'(ddy) + 51'(sb_ff);
      vy[1] = 51'(ddy) + 51'(sa_ff);
      vy[2] = 51'(ddy) - 51'(sa_ff);
      vy[3] = 51'(ddy) - 51'(sb_ff);
      for (int k = 0; k < 4; k++) begin
         mag      = vx[k][50] ? 51'(-vx[k]) : vx[k];
         xs_in[k] = ({mag, 1'b0} > {5'b0, lx, 31'b0}) && !vx[k][50];
         xa_in[k] = ({mag, 1'b0} > {5'b0, lx, 31'b0}) && vx[k][50];
         mag      = vy[k][50] ? 51'(-vy[k]) : vy[k];
         ys_in[k] = ({mag, 1'b0} > {5'b0, ly, 31'b0}) && !vy[k][50];
         ya_in[k] = ({mag, 1'b0} > {5'b0, ly, 31'b0}) && vy[k][50];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         u_ff    <= u_in;
         w_ff    <= w_in;
         xs_ff   <= xs_in;
         xa_ff   <= xa_in;
         ys_ff   <= ys_in;
         ya_ff   <= ya_in;
         cdx3_ff <= cdx2_ff;
         cdy3_ff <= cdy2_ff;
         sdx3_ff <= sdx2_ff;
         sdy3_ff <= sdy2_ff;
         clx3_ff <= clx2_ff;
         cly3_ff <= cly2_ff;
         slx3_ff <= slx2_ff;
         sly3_ff <= sly2_ff;
      end
   end

   // stage 4: center terms with wrap, side times rotated offsets in halves
   always_comb begin
      logic signed [52:0] tcx, tsy, tcy, tsx;
      for (int k = 0; k < 4; k++) begin
         tcx = 53'(cdx3_ff);
         tsx = 53'(sdx3_ff);
         tcy = 53'(cdy3_ff);
         tsy = 53'(sdy3_ff);
         if (xs_ff[k]) begin
            tcx = tcx - 53'(clx3_ff);
            tsx = tsx - 53'(slx3_ff);
         end else if (xa_ff[k]) begin
            tcx = tcx + 53'(clx3_ff);
            tsx = tsx + 53'(slx3_ff);
         end
         if (ys_ff[k]) begin
            tcy = tcy - 53'(cly3_ff);
            tsy = tsy - 53'(sly3_ff);
         end else if (ya_ff[k]) begin
            tcy = tcy + 53'(cly3_ff);
            tsy = tsy + 53'(sly3_ff);
         end
         p1_in[k] = tcx + tsy;
         p2_in[k] = tcy - tsx;
      end
   end

   assign rul_in = {1'b0, side} * u_ff[33:0];
   assign rwl_in = {1'b0, side} * w_ff[33:0];
   assign ruh_in = $signed({1'b0, side}) * $signed(u_ff[67:34]);
   assign rwh_in = $signed({1'b0, side}) * $signed(w_ff[67:34]);

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 4; k++) begin
            p1_ff[k] <= p1_in[k];
            p2_ff[k] <= p2_in[k];
         end
         rul_ff <= rul_in;
         rwl_ff <= rwl_in;
         ruh_ff <= ruh_in;
         rwh_ff <= rwh_in;
      end
   end

   // stage 5: join the halves
   assign ru_in = 88'($signed({ruh_ff, 34'b0})) + $signed({39'b0, rul_ff});
   assign rw_in = 88'($signed({rwh_ff, 34'b0})) + $signed({39'b0, rwl_ff});

   always_ff @(posedge clock) begin
      if (adv) begin
         ru_ff <= ru_in;
         rw_ff <= rw_in;
         for (int k = 0; k < 4; k++) begin
            p1b_ff[k] <= p1_ff[k];
            p2b_ff[k] <= p2_ff[k];
         end
      end
   end

   // stage 6: rotated corner coordinates, corners share U and W up to sign
   always_comb begin
      logic signed [87:0] q1 [4];
      logic signed [87:0] q2 [4];
      q1[0] = ru_ff;
      q2[0] = rw_ff;
      q1[1] = -rw_ff;
      q2[1] = ru_ff;
      q1[2] = rw_ff;
      q2[2] = -ru_ff;
      q1[3] = -ru_ff;
      q2[3] = -rw_ff;
      for (int k = 0; k < 4; k++) begin
         v1_in[k] = 88'($signed({p1b_ff[k], 31'b0})) + q1[k];
         v2_in[k] = 88'($signed({p2b_ff[k], 31'b0})) + q2[k];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 4; k++) begin
            v1_ff[k] <= v1_in[k];
            v2_ff[k] <= v2_in[k];
         end
      end
   end

   // stage 7: strictly inside the half side on both axes
   assign lim = $signed({13'b0, side, 60'b0});

   always_comb begin
      hit_in = 1'b0;
      for (int k = 0; k < 4; k++) begin
         if (v1_ff[k] < lim && v1_ff[k] > -lim && v2_ff[k] < lim && v2_ff[k] > -lim) begin
            hit_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hit_ff <= hit_in;
      end
   end

   assign hit = hit_ff;

endmodule

[rtl/core/rotated_square_overlap_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_square_overlap_test: oriented square overlap in a periodic box
// Pair-wise overlap of two equal rotated squares (or discs) with minimum image
// displacement, exact fixed-point arithmetic, one pair per cycle unless held.
// ----------------------------------------------------------------------------
// The block takes one particle pair per clock while it is not stalled and
// returns one overlap bit per pair, in order: two front-end stages (wrap,
// squares, cos/sin, distance gates), seven stages in each of the two corner
// units that run side by side (first square in the frame of the second and
// the reverse), then the output register. The corner units' multiplier
// stages set the depth; throughput is one beat per cycle while the result
// side does not stall. A stall on the result side freezes the whole pipeline
// and raises req_stall in the same cycle, so no beat is dropped or repeated.
// Write configuration only while the pipeline is empty.
// ----------------------------------------------------------------------------
module rotated_square_overlap_test import rsq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // pair input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_x_first,
   input  logic [15:0] req_y_first,
   input  logic [15:0] req_qz_first,
   input  logic [15:0] req_qw_first,
   input  logic [15:0] req_x_second,
   input  logic [15:0] req_y_second,
   input  logic [15:0] req_qz_second,
   input  logic [15:0] req_qw_second,
   // result output
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_overlap,
   // configuration
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic [15:0]         box_x_ff, box_y_ff;
   logic [14:0]         side_ff;
   logic                disc_ff;
   logic                adv;
   logic [PIPE_DEPTH-1:0] vld_ff;
   rsq_front_type       front;
   logic [CORNER_LAT-1:0] far_ff, near_ff, disc_p_ff;
   logic                hit_a, hit_b;
   logic signed [16:0]  ndx, ndy;
   logic                overlap_in;
   logic                rsp_valid_ff, rsp_overlap_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         box_x_ff <= BOX_RESET;
         box_y_ff <= BOX_RESET;
         side_ff  <= SIDE_RESET;
         disc_ff  <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_BOX_X: box_x_ff <= csr_data;
            CSR_BOX_Y: box_y_ff <= csr_data;
            CSR_SIDE:  side_ff  <= csr_data[14:0];
            CSR_DISC:  disc_ff  <= csr_data[0];
            default:   ;
         endcase
      end
   end

   // advance every stage unless the output beat is held
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], req_valid};
      end
   end

   rsq_front u_front (
      .clock     (clock),
      .adv       (adv),
      .x_first   (req_x_first),
      .y_first   (req_y_first),
      .qz_first  (req_qz_first),
      .qw_first  (req_qw_first),
      .x_second  (req_x_second),
      .y_second  (req_y_second),
      .qz_second (req_qz_second),
      .qw_second (req_qw_second),
      .box_x     (box_x_ff),
      .box_y     (box_y_ff),
      .side      (side_ff),
      .disc      (disc_ff),
      .front     (front)
   );

   // second square seen from the first
   rsq_corner u_corner_a (
      .clock (clock),
      .adv   (adv),
      .dx    (front.dx),
      .dy    (front.dy),
      .co    (front.c2),
      .so    (front.s2),
      .cf    (front.c1),
      .sf    (front.s1),
      .side  (side_ff),
      .lx    (box_x_ff),
      .ly    (box_y_ff),
      .hit   (hit_a)
   );

   // first square seen from the second: flip the displacement
   assign ndx = -front.dx;
   assign ndy = -front.dy;

   rsq_corner u_corner_b (
      .clock (clock),
      .adv   (adv),
      .dx    (ndx),
      .dy    (ndy),
      .co    (front.c1),
      .so    (front.s1),
      .cf    (front.c2),
      .sf    (front.s2),
      .side  (side_ff),
      .lx    (box_x_ff),
      .ly    (box_y_ff),
      .hit   (hit_b)
   );

   // hold the distance gates in step with the corner units
   always_ff @(posedge clock) begin
      if (adv) begin
         far_ff    <= {far_ff[CORNER_LAT-2:0], front.far};
         near_ff   <= {near_ff[CORNER_LAT-2:0], front.near};
         disc_p_ff <= {disc_p_ff[CORNER_LAT-2:0], front.disc};
      end
   end

   // disc: distance only; square: far drops, near hits, else corner test
   always_comb begin
      if (disc_p_ff[CORNER_LAT-1]) begin
         overlap_in = near_ff[CORNER_LAT-1];
      end else if (far_ff[CORNER_LAT-1]) begin
         overlap_in = 1'b0;
      end else if (near_ff[CORNER_LAT-1]) begin
         overlap_in = 1'b1;
      end else begin
         overlap_in = hit_a || hit_b;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vld_ff[PIPE_DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_overlap_ff <= overlap_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_overlap = rsp_overlap_ff;

   // the input only stalls behind a held output beat
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a held result");

   // a far pair in square mode never reports overlap
   a_far_clear: assert property (@(posedge clock) disable iff (reset)
      (adv && vld_ff[PIPE_DEPTH-1] && far_ff[CORNER_LAT-1] && !disc_p_ff[CORNER_LAT-1])
      |=> !rsp_overlap)
      else $error("far pair reported as overlapping");

   // a near pair always reports overlap
   a_near_hit: assert property (@(posedge clock) disable iff (reset)
      (adv && vld_ff[PIPE_DEPTH-1] && near_ff[CORNER_LAT-1]) |=> rsp_overlap)
      else $error("near pair reported as clear");

endmodule
